// ===== design/silhouette_mask_compare_unit_macros.svh =====
// Assertion macros for the silhouette mask compare unit.
`ifndef SILHOUETTE_MASK_COMPARE_UNIT_MACROS_SVH
`define SILHOUETTE_MASK_COMPARE_UNIT_MACROS_SVH

// The condition must hold in every cycle in which the trigger is high.
`define SMC_ASSERT_WHEN(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger is high.
`define SMC_ASSERT_AFTER(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/smc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes of the silhouette mask compare unit.
package smc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SIZE_W = 11;
  localparam int SPAN_A = (SIZE_W > COL_W + 1) ? SIZE_W : COL_W + 1;
  localparam int SPAN_W = (SPAN_A > ROW_W + 1) ? SPAN_A : ROW_W + 1;

  localparam int BYTE_W     = 8;
  localparam int SUM_W      = 10;
  localparam int TOL_W      = 16;
  localparam int TOL_FRAC_W = 8;
  localparam int CNT_W      = 21;
  localparam int CNT_SUM_W  = CNT_W + 2;
  localparam int CELL_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VERDICT_W  = 2;
  localparam int GREEN_W    = 7;

  localparam logic [SUM_W-1:0]   MASK_THRESHOLD = 10'd384;
  localparam logic [CNT_W-1:0]   CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [SIZE_W-1:0]  SIZE_RESET     = 11'd1024;
  localparam logic [TOL_W-1:0]   TOL_RESET      = 16'd512;
  localparam logic [BYTE_W-1:0]  DIFF_FULL      = 8'd255;
  localparam logic [GREEN_W-1:0] DIFF_BOTH      = 7'd90;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd2;

  localparam logic [VERDICT_W-1:0] VERDICT_AGREE   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_EXCEEDS = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_EMPTY   = 2'd2;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic              ma;
    logic              mb;
    logic              has_above;
    logic              above_top;
    logic              beyond;
    logic              col_zero;
    logic              row_end;
    logic              last_row;
    logic              frame_end;
    logic              hit_cell;
    logic              hit_right;
    logic [CELL_W-1:0] fwd;
  } px_t;

  typedef struct packed {
    logic             ma;
    logic             mb;
    logic             frame_end;
    logic [CNT_W-1:0] inter;
    logic [CNT_W-1:0] uni;
    logic [CNT_W-1:0] only_a;
    logic [CNT_W-1:0] only_b;
    logic [CNT_W-1:0] perim;
  } tally_t;

endpackage

// ===== design/smc_row_ram.sv =====
`timescale 1ns / 1ps
// Row buffer memory with one write port and two registered read ports.
module smc_row_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 2,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_a,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== design/smc_front.sv =====
`timescale 1ns / 1ps
// Input stage: raster position, mask decision, row buffer reads and forwarding.
module smc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [smc_pkg::BYTE_W-1:0]         a_blue,
  input  logic [smc_pkg::BYTE_W-1:0]         a_green,
  input  logic [smc_pkg::BYTE_W-1:0]         a_red,
  input  logic [smc_pkg::BYTE_W-1:0]         b_blue,
  input  logic [smc_pkg::BYTE_W-1:0]         b_green,
  input  logic [smc_pkg::BYTE_W-1:0]         b_red,
  input  logic [smc_pkg::SIZE_W-1:0]         frame_width,
  input  logic [smc_pkg::SIZE_W-1:0]         frame_height,
  input  smc_pkg::ram_wr_t                   ram_wr,
  input  logic                               s1_take,
  output logic                               s1_valid,
  output smc_pkg::px_t                       px,
  output logic                               rd_en,
  output logic [smc_pkg::COL_W-1:0]          rd_addr_cell,
  output logic [smc_pkg::COL_W-1:0]          rd_addr_right
);

  logic [smc_pkg::COL_W-1:0]  column_pos;
  logic [smc_pkg::COL_W-1:0]  column_pos_next;
  logic [smc_pkg::ROW_W-1:0]  row_pos;
  logic [smc_pkg::ROW_W-1:0]  row_pos_next;
  logic [smc_pkg::SPAN_W-1:0] width_eff;
  logic [smc_pkg::SPAN_W-1:0] height_eff;
  logic [smc_pkg::SPAN_W-1:0] x_ext;
  logic [smc_pkg::SPAN_W-1:0] y_ext;
  logic                       row_end;
  logic                       last_row;
  logic                       accept;
  smc_pkg::px_t               px_next;

  function automatic logic [smc_pkg::SPAN_W-1:0] clamp_size(
    input logic [smc_pkg::SIZE_W-1:0] v,
    input logic [smc_pkg::SPAN_W-1:0] limit
  );
    logic [smc_pkg::SPAN_W-1:0] ve;
    ve = smc_pkg::SPAN_W'(v);
    priority if (ve == '0) begin
      return smc_pkg::SPAN_W'(1);
    end else if (ve > limit) begin
      return limit;
    end else begin
      return ve;
    end
  endfunction

  function automatic logic mask_of(
    input logic [smc_pkg::BYTE_W-1:0] b,
    input logic [smc_pkg::BYTE_W-1:0] g,
    input logic [smc_pkg::BYTE_W-1:0] r
  );
    logic [smc_pkg::SUM_W-1:0] sum;
    sum = smc_pkg::SUM_W'(b) + smc_pkg::SUM_W'(g) + smc_pkg::SUM_W'(r);
    return sum >= smc_pkg::MASK_THRESHOLD;
  endfunction

  assign width_eff  = clamp_size(frame_width, smc_pkg::SPAN_W'(smc_pkg::MAX_WIDTH));
  assign height_eff = clamp_size(frame_height, smc_pkg::SPAN_W'(smc_pkg::MAX_HEIGHT));
  assign x_ext      = smc_pkg::SPAN_W'(column_pos);
  assign y_ext      = smc_pkg::SPAN_W'(row_pos);
  assign row_end    = (x_ext + smc_pkg::SPAN_W'(1)) >= width_eff;
  assign last_row   = (y_ext + smc_pkg::SPAN_W'(1)) >= height_eff;

  assign in_ready      = !rst && (!s1_valid || s1_take);
  assign accept        = in_valid && in_ready;
  assign rd_en         = accept;
  assign rd_addr_cell  = column_pos;
  assign rd_addr_right = column_pos + smc_pkg::COL_W'(1);

  always_comb begin
    px_next.col       = column_pos;
    px_next.ma        = mask_of(a_blue, a_green, a_red);
    px_next.mb        = mask_of(b_blue, b_green, b_red);
    px_next.has_above = (row_pos != '0);
    px_next.above_top = (row_pos == smc_pkg::ROW_W'(1));
    px_next.beyond    = (y_ext >= height_eff);
    px_next.col_zero  = (column_pos == '0);
    px_next.row_end   = row_end;
    px_next.last_row  = last_row;
    px_next.frame_end = row_end && last_row;
    px_next.hit_cell  = ram_wr.en && (ram_wr.addr == rd_addr_cell);
    px_next.hit_right = ram_wr.en && (ram_wr.addr == rd_addr_right);
    px_next.fwd       = ram_wr.data;
  end

  always_comb begin
    column_pos_next = column_pos;
    row_pos_next    = row_pos;
    if (accept) begin
      priority if (row_end && last_row) begin
        column_pos_next = '0;
        row_pos_next    = '0;
      end else if (row_end) begin
        column_pos_next = '0;
        row_pos_next    = row_pos + smc_pkg::ROW_W'(1);
      end else begin
        column_pos_next = column_pos + smc_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      s1_valid   <= 1'b0;
    end else begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= px_next;
    end
  end

endmodule

// ===== design/smc_tally.sv =====
`timescale 1ns / 1ps
// Read-modify-write of the row buffer, perimeter judgement and the running totals.
module smc_tally (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s1_valid,
  input  smc_pkg::px_t                px,
  input  logic [smc_pkg::CELL_W-1:0]  rd_cell,
  input  logic [smc_pkg::CELL_W-1:0]  rd_right,
  input  logic                        s2_take,
  output logic                        s1_take,
  output smc_pkg::ram_wr_t            ram_wr,
  output logic                        s2_valid,
  output smc_pkg::tally_t             tally
);

  logic [smc_pkg::CNT_W-1:0]  inter_total;
  logic [smc_pkg::CNT_W-1:0]  union_total;
  logic [smc_pkg::CNT_W-1:0]  only_a_total;
  logic [smc_pkg::CNT_W-1:0]  only_b_total;
  logic [smc_pkg::CNT_W-1:0]  edge_total;
  logic [smc_pkg::CNT_W-1:0]  inter_total_next;
  logic [smc_pkg::CNT_W-1:0]  union_total_next;
  logic [smc_pkg::CNT_W-1:0]  only_a_total_next;
  logic [smc_pkg::CNT_W-1:0]  only_b_total_next;
  logic [smc_pkg::CNT_W-1:0]  edge_total_next;
  logic [smc_pkg::CELL_W-1:0] cur_entry;
  logic [smc_pkg::CELL_W-1:0] right_cell;
  logic                       left_bit;
  logic                       judge;
  logic                       perim_hit;
  logic [1:0]                 edge_inc;

  function automatic logic [smc_pkg::CNT_W-1:0] sat_add(
    input logic [smc_pkg::CNT_W-1:0] c,
    input logic [1:0]                inc
  );
    logic [smc_pkg::CNT_W:0] sum;
    sum = (smc_pkg::CNT_W + 1)'(c) + (smc_pkg::CNT_W + 1)'(inc);
    if (sum > (smc_pkg::CNT_W + 1)'(smc_pkg::CNT_MAX)) begin
      return smc_pkg::CNT_MAX;
    end
    return sum[smc_pkg::CNT_W-1:0];
  endfunction

  assign cur_entry  = px.hit_cell ? px.fwd : rd_cell;
  assign right_cell = px.hit_right ? px.fwd : rd_right;
  assign judge      = px.has_above && cur_entry[0];
  assign perim_hit  = px.above_top || px.beyond || px.col_zero || px.row_end ||
                      !left_bit || !right_cell[0] || !cur_entry[1] || !px.ma;
  assign edge_inc   = {1'b0, judge && perim_hit} + {1'b0, px.ma && px.last_row};

  assign s1_take     = s1_valid && (!s2_valid || s2_take);
  assign ram_wr.en   = s1_take;
  assign ram_wr.addr = px.col;
  assign ram_wr.data = {cur_entry[0], px.ma};

  assign inter_total_next  = sat_add(inter_total, {1'b0, px.ma && px.mb});
  assign union_total_next  = sat_add(union_total, {1'b0, px.ma || px.mb});
  assign only_a_total_next = sat_add(only_a_total, {1'b0, px.ma && !px.mb});
  assign only_b_total_next = sat_add(only_b_total, {1'b0, !px.ma && px.mb});
  assign edge_total_next   = sat_add(edge_total, edge_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      inter_total  <= '0;
      union_total  <= '0;
      only_a_total <= '0;
      only_b_total <= '0;
      edge_total   <= '0;
      s2_valid     <= 1'b0;
    end else begin
      if (s1_take) begin
        inter_total  <= px.frame_end ? '0 : inter_total_next;
        union_total  <= px.frame_end ? '0 : union_total_next;
        only_a_total <= px.frame_end ? '0 : only_a_total_next;
        only_b_total <= px.frame_end ? '0 : only_b_total_next;
        edge_total   <= px.frame_end ? '0 : edge_total_next;
        s2_valid     <= 1'b1;
      end else if (s2_take) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      left_bit        <= cur_entry[0];
      tally.ma        <= px.ma;
      tally.mb        <= px.mb;
      tally.frame_end <= px.frame_end;
      tally.inter     <= px.frame_end ? inter_total_next : '0;
      tally.uni       <= px.frame_end ? union_total_next : '0;
      tally.only_a    <= px.frame_end ? only_a_total_next : '0;
      tally.only_b    <= px.frame_end ? only_b_total_next : '0;
      tally.perim     <= px.frame_end ? edge_total_next : '0;
    end
  end

endmodule

// ===== design/smc_verdict.sv =====
`timescale 1ns / 1ps
// Output stage: difference colour, tolerance verdict and the result register.
module smc_verdict (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s2_valid,
  input  smc_pkg::tally_t                  tally,
  input  logic [smc_pkg::TOL_W-1:0]        tolerance_q8,
  output logic                             s2_take,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [smc_pkg::BYTE_W-1:0]       diff_red,
  output logic [smc_pkg::GREEN_W-1:0]      diff_green,
  output logic [smc_pkg::BYTE_W-1:0]       diff_blue,
  output logic                             frame_done,
  output logic [smc_pkg::VERDICT_W-1:0]    verdict,
  output logic [smc_pkg::CNT_W-1:0]        intersection_count,
  output logic [smc_pkg::CNT_W-1:0]        union_count,
  output logic [smc_pkg::CNT_W-1:0]        only_a_count,
  output logic [smc_pkg::CNT_W-1:0]        only_b_count,
  output logic [smc_pkg::CNT_W-1:0]        perimeter_count
);

  localparam int DiffW = smc_pkg::CNT_W + 1;
  localparam int ScaledW = DiffW + smc_pkg::TOL_FRAC_W;
  localparam int ProdW = smc_pkg::TOL_W + smc_pkg::CNT_W;

  logic [DiffW-1:0]              diff_sum;
  logic [ScaledW-1:0]            diff_scaled;
  logic [ProdW-1:0]              allowed;
  logic [smc_pkg::VERDICT_W-1:0] verdict_next;

  assign diff_sum    = DiffW'(tally.only_a) + DiffW'(tally.only_b);
  assign diff_scaled = {diff_sum, {smc_pkg::TOL_FRAC_W{1'b0}}};
  assign allowed     = ProdW'(tolerance_q8) * ProdW'(tally.perim);

  always_comb begin
    priority if (!tally.frame_end) begin
      verdict_next = smc_pkg::VERDICT_AGREE;
    end else if (tally.uni == '0) begin
      verdict_next = smc_pkg::VERDICT_EMPTY;
    end else if (ProdW'(diff_scaled) > allowed) begin
      verdict_next = smc_pkg::VERDICT_EXCEEDS;
    end else begin
      verdict_next = smc_pkg::VERDICT_AGREE;
    end
  end

  assign s2_take = s2_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      diff_red           <= (tally.ma && !tally.mb) ? smc_pkg::DIFF_FULL : '0;
      diff_green         <= (tally.ma && tally.mb) ? smc_pkg::DIFF_BOTH : '0;
      diff_blue          <= (!tally.ma && tally.mb) ? smc_pkg::DIFF_FULL : '0;
      frame_done         <= tally.frame_end;
      verdict            <= verdict_next;
      intersection_count <= tally.inter;
      union_count        <= tally.uni;
      only_a_count       <= tally.only_a;
      only_b_count       <= tally.only_b;
      perimeter_count    <= tally.perim;
    end
  end

endmodule

// ===== design/silhouette_mask_compare_unit.sv =====
`timescale 1ns / 1ps
// Top level of the silhouette mask compare unit with its configuration registers.
//
//   Channel  Handshake              Beat
//   in       in_valid / in_ready    one pixel pair: a_blue .. b_red
//   out      out_valid / out_ready  difference colour, frame_done, verdict, totals
//   cfg      cfg_valid / cfg_ready  cfg_index and cfg_data, one register write
//
// One pixel beat is taken per cycle unless in_ready is low; each pixel costs one
// read-modify-write of its row buffer entry, the write landing as the pixel leaves stage one.
// A result passes the buffer read, tally and verdict registers before it is presented.
// Reset clears position, totals and stage flags; the row buffer needs no clearing pass.
// With the output stalled, two more results are held inside before in_ready falls.
`include "silhouette_mask_compare_unit_macros.svh"

module silhouette_mask_compare_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [smc_pkg::BYTE_W-1:0]         a_blue,
  input  logic [smc_pkg::BYTE_W-1:0]         a_green,
  input  logic [smc_pkg::BYTE_W-1:0]         a_red,
  input  logic [smc_pkg::BYTE_W-1:0]         b_blue,
  input  logic [smc_pkg::BYTE_W-1:0]         b_green,
  input  logic [smc_pkg::BYTE_W-1:0]         b_red,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [smc_pkg::BYTE_W-1:0]         diff_red,
  output logic [smc_pkg::GREEN_W-1:0]        diff_green,
  output logic [smc_pkg::BYTE_W-1:0]         diff_blue,
  output logic                               frame_done,
  output logic [smc_pkg::VERDICT_W-1:0]      verdict,
  output logic [smc_pkg::CNT_W-1:0]          intersection_count,
  output logic [smc_pkg::CNT_W-1:0]          union_count,
  output logic [smc_pkg::CNT_W-1:0]          only_a_count,
  output logic [smc_pkg::CNT_W-1:0]          only_b_count,
  output logic [smc_pkg::CNT_W-1:0]          perimeter_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [smc_pkg::SIZE_W-1:0] frame_width;
  logic [smc_pkg::SIZE_W-1:0] frame_height;
  logic [smc_pkg::TOL_W-1:0]  tolerance_q8;
  logic                       s1_valid;
  logic                       s1_take;
  logic                       s2_valid;
  logic                       s2_take;
  logic                       rd_en;
  logic [smc_pkg::COL_W-1:0]  rd_addr_cell;
  logic [smc_pkg::COL_W-1:0]  rd_addr_right;
  logic [smc_pkg::CELL_W-1:0] rd_cell;
  logic [smc_pkg::CELL_W-1:0] rd_right;
  smc_pkg::px_t               px;
  smc_pkg::ram_wr_t           ram_wr;
  smc_pkg::tally_t            tally;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= smc_pkg::SIZE_RESET;
      frame_height <= smc_pkg::SIZE_RESET;
      tolerance_q8 <= smc_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smc_pkg::CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data[smc_pkg::SIZE_W-1:0];
        end
        smc_pkg::CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[smc_pkg::SIZE_W-1:0];
        end
        smc_pkg::CFG_TOLERANCE: begin
          tolerance_q8 <= cfg_data[smc_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  smc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .a_blue        (a_blue),
    .a_green       (a_green),
    .a_red         (a_red),
    .b_blue        (b_blue),
    .b_green       (b_green),
    .b_red         (b_red),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .ram_wr        (ram_wr),
    .s1_take       (s1_take),
    .s1_valid      (s1_valid),
    .px            (px),
    .rd_en         (rd_en),
    .rd_addr_cell  (rd_addr_cell),
    .rd_addr_right (rd_addr_right)
  );

  smc_row_ram #(
    .DEPTH  (smc_pkg::MAX_WIDTH),
    .WIDTH  (smc_pkg::CELL_W),
    .ADDR_W (smc_pkg::COL_W)
  ) u_row_ram (
    .clk       (clk),
    .wr_en     (ram_wr.en),
    .wr_addr   (ram_wr.addr),
    .wr_data   (ram_wr.data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_cell),
    .rd_addr_b (rd_addr_right),
    .rd_data_a (rd_cell),
    .rd_data_b (rd_right)
  );

  smc_tally u_tally (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .px       (px),
    .rd_cell  (rd_cell),
    .rd_right (rd_right),
    .s2_take  (s2_take),
    .s1_take  (s1_take),
    .ram_wr   (ram_wr),
    .s2_valid (s2_valid),
    .tally    (tally)
  );

  smc_verdict u_verdict (
    .clk                (clk),
    .rst                (rst),
    .s2_valid           (s2_valid),
    .tally              (tally),
    .tolerance_q8       (tolerance_q8),
    .s2_take            (s2_take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .diff_red           (diff_red),
    .diff_green         (diff_green),
    .diff_blue          (diff_blue),
    .frame_done         (frame_done),
    .verdict            (verdict),
    .intersection_count (intersection_count),
    .union_count        (union_count),
    .only_a_count       (only_a_count),
    .only_b_count       (only_b_count),
    .perimeter_count    (perimeter_count)
  );

  `SMC_ASSERT_WHEN(a_totals_only_at_frame_end, out_valid && !frame_done, (intersection_count == '0) && (union_count == '0) && (only_a_count == '0) && (only_b_count == '0) && (perimeter_count == '0) && (verdict == smc_pkg::VERDICT_AGREE), "totals reported on a beat that does not end a frame")
  `SMC_ASSERT_WHEN(a_union_split, out_valid && frame_done, smc_pkg::CNT_SUM_W'(union_count) == smc_pkg::CNT_SUM_W'(intersection_count) + smc_pkg::CNT_SUM_W'(only_a_count) + smc_pkg::CNT_SUM_W'(only_b_count), "union total does not match its parts")
  `SMC_ASSERT_WHEN(a_empty_verdict, out_valid && frame_done, (verdict == smc_pkg::VERDICT_EMPTY) == (union_count == '0), "empty verdict disagrees with the union total")
  `SMC_ASSERT_AFTER(a_beat_enters_pipe, in_valid && in_ready, s1_valid, "accepted pixel beat did not reach the first stage")
  `SMC_ASSERT_WHEN(a_full_pipe_blocks, s1_valid && s2_valid && out_valid && !out_ready, !in_ready, "input open while every stage is held")

endmodule
